// ===== hdl/ubtv_pkg.sv =====
// shared types and constants for the bounded utf-8 text validator
// no dependencies; imported by ubtv_step and utf8_bounded_text_validator
`default_nettype none

package ubtv_pkg;

  localparam int CNT_W = 17;
  localparam logic [CNT_W-1:0] CNT_MAX = 17'h1FFFF;
  localparam logic [CNT_W-1:0] MAX_LENGTH_RST = 17'h10000;
  localparam int CP_W = 21;

  // lead byte ranges
  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] LEAD2_MIN = 8'hC2;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD4_MAX = 8'hF4;
  localparam logic [1:0] CONT_TAG = 2'b10;

  // code point limits
  localparam logic [CP_W-1:0] CP_MIN2 = 21'h00080;
  localparam logic [CP_W-1:0] CP_MIN3 = 21'h00800;
  localparam logic [CP_W-1:0] CP_MIN4 = 21'h10000;
  localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO = 21'h0D800;
  localparam logic [CP_W-1:0] SURR_HI = 21'h0DFFF;

  typedef enum logic [1:0] {
    SEQ_NONE  = 2'd0,
    SEQ_TWO   = 2'd1,
    SEQ_THREE = 2'd2,
    SEQ_FOUR  = 2'd3
  } seq_class_t;

  typedef struct packed {
    logic [1:0]       pend;
    logic [CP_W-1:0]  cp;
    seq_class_t       cls;
    logic [CNT_W-1:0] cnt;
    logic             err;
  } dec_state_t;

  localparam dec_state_t DEC_STATE_RST = '{
    pend: 2'd0, cp: '0, cls: SEQ_NONE, cnt: '0, err: 1'b0
  };

endpackage

`default_nettype wire

// ===== hdl/ubtv_step.sv =====
// one-item decode step: next decoder state and verdict for one input item
// depends on ubtv_pkg
`default_nettype none

module ubtv_step (
  input  ubtv_pkg::dec_state_t          cur,
  input  logic [ubtv_pkg::CNT_W-1:0]    max_length,
  input  logic [7:0]                    data_byte,
  input  logic                          has_byte,
  input  logic                          is_last,
  output ubtv_pkg::dec_state_t          nxt,
  output logic                          text_valid,
  output logic [ubtv_pkg::CNT_W-1:0]    byte_count
);
  import ubtv_pkg::*;

  logic [CNT_W-1:0] cap;
  logic [CP_W-1:0]  cp_acc;
  logic [CP_W-1:0]  cp_min;
  dec_state_t       st;

  always_comb begin
    cap = (max_length < CNT_MAX) ? max_length + 17'd1 : CNT_MAX;
    cp_acc = {cur.cp[CP_W-7:0], data_byte[5:0]};
    case (cur.cls)
      SEQ_TWO:   cp_min = CP_MIN2;
      SEQ_THREE: cp_min = CP_MIN3;
      default:   cp_min = CP_MIN4;
    endcase

    st = cur;
    if (has_byte) begin
      if (cur.cnt >= max_length) st.err = 1'b1;
      if (cur.cnt < cap) st.cnt = cur.cnt + 17'd1;

      if (cur.pend == 2'd0) begin
        if (data_byte == 8'h00) begin
          st.err = 1'b1;
        end else if (data_byte <= ASCII_MAX) begin
          st.err = st.err;
        end else if (data_byte >= LEAD2_MIN && data_byte <= LEAD2_MAX) begin
          st.pend = 2'd1;
          st.cp   = {16'd0, data_byte[4:0]};
          st.cls  = SEQ_TWO;
        end else if (data_byte >= LEAD3_MIN && data_byte <= LEAD3_MAX) begin
          st.pend = 2'd2;
          st.cp   = {17'd0, data_byte[3:0]};
          st.cls  = SEQ_THREE;
        end else if (data_byte >= LEAD4_MIN && data_byte <= LEAD4_MAX) begin
          st.pend = 2'd3;
          st.cp   = {18'd0, data_byte[2:0]};
          st.cls  = SEQ_FOUR;
        end else begin
          st.err = 1'b1;
        end
      end else if (data_byte[7:6] != CONT_TAG) begin
        // bad continuation drops the open sequence
        st.err  = 1'b1;
        st.pend = 2'd0;
        st.cp   = '0;
        st.cls  = SEQ_NONE;
      end else begin
        st.cp   = cp_acc;
        st.pend = cur.pend - 2'd1;
        if (cur.pend == 2'd1) begin
          if (cp_acc < cp_min || cp_acc > CP_MAX ||
              (cp_acc >= SURR_LO && cp_acc <= SURR_HI)) begin
            st.err = 1'b1;
          end
          st.cp  = '0;
          st.cls = SEQ_NONE;
        end
      end
    end

    // truncated sequence at end of string
    if (st.pend != 2'd0) begin
      text_valid = 1'b0;
    end else begin
      text_valid = ~st.err;
    end
    byte_count = st.cnt;

    nxt = is_last ? DEC_STATE_RST : st;
  end

endmodule

`default_nettype wire

// ===== hdl/utf8_bounded_text_validator.sv =====
// top level of the bounded utf-8 text validator: input register, decode step,
// result register; depends on ubtv_pkg and ubtv_step
`default_nettype none

// path: an accepted item sits in the input register, and the result register loads
//   when the item retires; only last items give a result
// throughput: one item per clock; a last item waits while an untaken result is held
// reset (rst, synchronous): decoder state cleared, both registers empty,
//   max_length back to 65536
module utf8_bounded_text_validator (
  input  logic        clk,
  input  logic        rst,
  // configuration: max_length
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] has_byte
  input  logic        s_axis_tlast,   // is_last
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [0] text_valid, [17:1] byte_count, [23:18] zero
);
  import ubtv_pkg::*;

  // configuration register
  logic [CNT_W-1:0] max_length;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_has;
  logic       in_last;

  // decoder state
  dec_state_t state;
  dec_state_t state_next;

  // result register
  logic             out_valid;
  logic             out_text_valid;
  logic [CNT_W-1:0] out_count;

  logic             step_text_valid;
  logic [CNT_W-1:0] step_count;
  logic             out_free;
  logic             advance;

  // the result register frees up when empty or taken this cycle
  assign out_free = ~out_valid | m_axis_tready;
  // items without a result never wait for the output side
  assign advance = in_valid & (~in_last | out_free);
  assign s_axis_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RST;
    end else if (cfg_wr_en) begin
      max_length <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_has  <= s_axis_tuser;
      in_last <= s_axis_tlast;
    end
  end

  ubtv_step u_step (
    .cur        (state),
    .max_length (max_length),
    .data_byte  (in_byte),
    .has_byte   (in_has),
    .is_last    (in_last),
    .nxt        (state_next),
    .text_valid (step_text_valid),
    .byte_count (step_count)
  );

  // decoder state only moves when the held item retires
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DEC_STATE_RST;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_text_valid <= step_text_valid;
      out_count      <= step_count;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_count, out_text_valid};

endmodule

`default_nettype wire
